FILE: hdl/ddo_pkg.sv
// Shared types, constants and helper functions for the differential drive odometry core.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package ddo_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_WHEEL_DIAMETER = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WHEEL_BASE     = 8'd1;
    localparam logic [15:0] DIAMETER_RESET = 16'd2048;
    localparam logic [15:0] BASE_RESET     = 16'd4096;

    // Distance per degree: round(diameter * pi * 2^32 / (360 * 2^16)).
    // The divisor is 45 * 2^19: shift out 2^19, then multiply by ceil(2^37 / 45) and
    // keep bits 62:37, exact for every 31-bit numerator.
    localparam logic [33:0] PIQ32        = 34'd13493037705;
    localparam logic [49:0] DPD_ROUND    = 50'd11796480;
    localparam logic [31:0] DPD_RECIP    = 32'd3054198967;

    // Serial divider
    localparam int DIV_W = 59;
    localparam logic [5:0] TURN_STEPS = 6'd59;
    localparam logic [21:0] TURN_MOD  = 22'd1647100;

    // Angles, Q16 radians
    localparam logic signed [22:0] PI_Q16       = 23'sd205887;
    localparam logic signed [22:0] TWO_PI_Q16   = 23'sd411775;
    localparam logic signed [22:0] FOUR_PI_Q16  = 23'sd823550;
    localparam logic signed [22:0] HALF_PI_Q16  = 23'sd102944;

    // CORDIC
    localparam logic signed [33:0] CORDIC_K    = 34'sd652032874;
    localparam logic [4:0]         CORDIC_LAST = 5'd16;

    // Mean travel clamp, Q16 cm
    localparam logic signed [50:0] MEAN_LIMIT = 51'sh100_0000_0000;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_NUM,
        ST_DPD_START,
        ST_MUL_TR,
        ST_MUL_TL,
        ST_SUMS,
        ST_TURN_START,
        ST_TURN_WAIT,
        ST_TURN,
        ST_ANGLE,
        ST_CORDIC,
        ST_TRIG,
        ST_MXLO,
        ST_MXHI,
        ST_MYLO,
        ST_MYHI,
        ST_YFULL,
        ST_YSUM,
        ST_COMMIT
    } state_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_MUL_NUM,
        CMD_DPD_START,
        CMD_MUL_TR,
        CMD_MUL_TL,
        CMD_SUMS,
        CMD_TURN_START,
        CMD_TURN,
        CMD_ANGLE,
        CMD_CORDIC_STEP,
        CMD_TRIG,
        CMD_MXLO,
        CMD_MXHI,
        CMD_MYLO,
        CMD_MYHI,
        CMD_YFULL,
        CMD_YSUM,
        CMD_COMMIT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic cordic_last;
    } dp_status_t;

    // Arctangent of 2^-i in Q16
    function automatic logic [16:0] atan_q16(input logic [4:0] i);
        logic [16:0] r;
        unique case (i)
            5'd0:    r = 17'd51472;
            5'd1:    r = 17'd30386;
            5'd2:    r = 17'd16055;
            5'd3:    r = 17'd8150;
            5'd4:    r = 17'd4091;
            5'd5:    r = 17'd2047;
            5'd6:    r = 17'd1024;
            5'd7:    r = 17'd512;
            5'd8:    r = 17'd256;
            5'd9:    r = 17'd128;
            5'd10:   r = 17'd64;
            5'd11:   r = 17'd32;
            5'd12:   r = 17'd16;
            5'd13:   r = 17'd8;
            5'd14:   r = 17'd4;
            5'd15:   r = 17'd2;
            5'd16:   r = 17'd1;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        logic signed [31:0] r;
        if (v > 42'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -42'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ddo_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle, keeping only the quotient modulo
// the turn range and whether a remainder is left. Depends on ddo_pkg.
`default_nettype none

module ddo_divider (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [ddo_pkg::DIV_W-1:0] dividend,
    input  wire logic [15:0]               divisor,
    input  wire logic [5:0]                steps,
    output logic                           busy,
    output logic [20:0]                    quot_mod,
    output logic                           rem_nonzero
);

    logic                      busy_reg;
    logic [5:0]                count_reg;
    logic [ddo_pkg::DIV_W-1:0] num_reg;
    logic [15:0]               rem_reg;
    logic [15:0]               den_reg;
    logic [20:0]               qmod_reg;

    logic [16:0] trial;
    logic        qbit;
    logic [15:0] rem_next;
    logic [21:0] qm2;
    logic [20:0] qmod_next;

    always_comb begin
        trial = {rem_reg, num_reg[ddo_pkg::DIV_W-1]};
        if (trial >= {1'b0, den_reg}) begin
            qbit     = 1'b1;
            rem_next = 16'(trial - {1'b0, den_reg});
        end else begin
            qbit     = 1'b0;
            rem_next = trial[15:0];
        end
        // track quotient mod the turn range: value stays below twice the modulus
        qm2 = {qmod_reg, 1'b0} + {21'd0, qbit};
        if (qm2 >= ddo_pkg::TURN_MOD) begin
            qmod_next = 21'(qm2 - ddo_pkg::TURN_MOD);
        end else begin
            qmod_next = qm2[20:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            count_reg <= 6'd0;
        end else if (start) begin
            busy_reg  <= 1'b1;
            count_reg <= steps;
        end else if (busy_reg) begin
            count_reg <= count_reg - 6'd1;
            if (count_reg == 6'd1) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg  <= dividend;
            den_reg  <= divisor;
            rem_reg  <= 16'd0;
            qmod_reg <= 21'd0;
        end else if (busy_reg) begin
            num_reg  <= {num_reg[ddo_pkg::DIV_W-2:0], 1'b0};
            rem_reg  <= rem_next;
            qmod_reg <= qmod_next;
        end
    end

    assign busy        = busy_reg;
    assign quot_mod    = qmod_reg;
    assign rem_nonzero = (rem_reg != 16'd0);

endmodule

`default_nettype wire

FILE: hdl/ddo_datapath.sv
// Datapath: configuration registers, pose state, shared multiplier, CORDIC rotator and
// output registers. Depends on ddo_pkg and ddo_divider.
`default_nettype none

module ddo_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire ddo_pkg::ctrl_cmd_t              cmd,
    output ddo_pkg::dp_status_t                  status,
    input  wire logic                            cfg_valid,
    input  wire logic [ddo_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [15:0]                     cfg_data,
    input  wire logic signed [31:0]              right_count,
    input  wire logic signed [31:0]              left_count,
    output logic signed [31:0]                   pos_x,
    output logic signed [31:0]                   pos_y,
    output logic signed [18:0]                   heading
);

    logic [15:0] diam_reg;
    logic [15:0] base_reg;

    logic [31:0]        prev_right_reg, prev_left_reg;
    logic signed [31:0] dr_reg, dl_reg;
    logic signed [67:0] prod_reg;
    logic [25:0]        dpd_reg;
    logic signed [57:0] tr_reg;
    logic signed [41:0] mq_reg;
    logic               vneg_reg;
    logic [58:0]        vmag_reg;
    logic [20:0]        t17_reg;
    logic signed [18:0] hnew_reg;
    logic signed [18:0] cur_h_reg;
    logic signed [31:0] cur_x_reg, cur_y_reg;
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [19:0] cz_reg;
    logic               cneg_reg;
    logic [4:0]         step_reg;
    logic signed [25:0] cos_reg, sin_reg;
    logic signed [67:0] acc_lo_reg;
    logic signed [67:0] full_reg;
    logic signed [41:0] xsum_reg, ysum_reg;
    logic signed [31:0] out_x_reg, out_y_reg;
    logic signed [18:0] out_h_reg;

    // divider
    logic                      div_start;
    logic [ddo_pkg::DIV_W-1:0] div_dividend;
    logic [15:0]               div_divisor;
    logic [5:0]                div_steps;
    logic                      div_busy;
    logic [20:0]               div_qmod;
    logic                      div_rnz;
    logic [49:0]               dpd_sum;
    logic [25:0]               dpd_val;
    logic [15:0]               base_eff;

    assign base_eff = (base_reg == 16'd0) ? 16'd1 : base_reg;
    assign dpd_sum  = prod_reg[49:0] + ddo_pkg::DPD_ROUND;
    assign dpd_val  = prod_reg[62:37];

    always_comb begin
        div_start    = (cmd.op == ddo_pkg::CMD_TURN_START);
        div_dividend = vmag_reg;
        div_divisor  = base_eff;
        div_steps    = ddo_pkg::TURN_STEPS;
    end

    ddo_divider u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (div_start),
        .dividend    (div_dividend),
        .divisor     (div_divisor),
        .steps       (div_steps),
        .busy        (div_busy),
        .quot_mod    (div_qmod),
        .rem_nonzero (div_rnz)
    );

    // shared multiplier
    logic signed [34:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [67:0] mul_p;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            ddo_pkg::CMD_MUL_NUM: begin
                mul_a = $signed({1'b0, ddo_pkg::PIQ32});
                mul_b = $signed({17'd0, diam_reg});
            end
            ddo_pkg::CMD_DPD_START: begin
                mul_a = $signed({4'd0, dpd_sum[49:19]});
                mul_b = $signed({1'b0, ddo_pkg::DPD_RECIP});
            end
            ddo_pkg::CMD_MUL_TR: begin
                mul_a = 35'(dr_reg);
                mul_b = $signed({7'd0, dpd_val});
            end
            ddo_pkg::CMD_MUL_TL: begin
                mul_a = 35'(dl_reg);
                mul_b = $signed({7'd0, dpd_reg});
            end
            ddo_pkg::CMD_MXLO: begin
                mul_a = $signed({14'd0, mq_reg[20:0]});
                mul_b = 33'(cos_reg);
            end
            ddo_pkg::CMD_MXHI: begin
                mul_a = 35'($signed(mq_reg[41:21]));
                mul_b = 33'(cos_reg);
            end
            ddo_pkg::CMD_MYLO: begin
                mul_a = $signed({14'd0, mq_reg[20:0]});
                mul_b = 33'(sin_reg);
            end
            ddo_pkg::CMD_MYHI: begin
                mul_a = 35'($signed(mq_reg[41:21]));
                mul_b = 33'(sin_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = 68'(mul_a) * 68'(mul_b);
    end

    // travel sums
    logic signed [57:0] tl_val;
    logic signed [59:0] sum60, diff60;
    logic signed [50:0] mean16, mean_clamped;
    logic [59:0]        diff_mag;

    always_comb begin
        tl_val = prod_reg[57:0];
        sum60  = 60'(tr_reg) + 60'(tl_val);
        diff60 = 60'(tr_reg) - 60'(tl_val);
        mean16 = sum60[59:9];
        if (mean16 > ddo_pkg::MEAN_LIMIT) begin
            mean_clamped = ddo_pkg::MEAN_LIMIT;
        end else if (mean16 < -ddo_pkg::MEAN_LIMIT) begin
            mean_clamped = -ddo_pkg::MEAN_LIMIT;
        end else begin
            mean_clamped = mean16;
        end
        diff_mag = diff60[59] ? 60'(-diff60) : 60'(diff60);
    end

    // floor division of a negative value: negate and round the quotient away from zero
    logic [21:0] kval;
    logic [20:0] t17_val;

    always_comb begin
        kval = {1'b0, div_qmod} + {21'd0, div_rnz};
        if (!vneg_reg) begin
            t17_val = div_qmod;
        end else if (kval == 22'd0 || kval == ddo_pkg::TURN_MOD) begin
            t17_val = 21'd0;
        end else begin
            t17_val = 21'(ddo_pkg::TURN_MOD - kval);
        end
    end

    // heading wrap and quadrant fold
    logic signed [22:0] hs, ha, ang, ts, tw, hn, zf;
    logic               fold;

    always_comb begin
        hs = 23'(cur_h_reg) + $signed({4'd0, t17_reg[20:2]}) + ddo_pkg::PI_Q16;
        ha = (hs >= ddo_pkg::TWO_PI_Q16) ? hs - ddo_pkg::TWO_PI_Q16 : hs;
        ang = ha - ddo_pkg::PI_Q16;
        if (ang > ddo_pkg::HALF_PI_Q16) begin
            zf   = ang - ddo_pkg::PI_Q16;
            fold = 1'b1;
        end else if (ang < -ddo_pkg::HALF_PI_Q16) begin
            zf   = ang + ddo_pkg::PI_Q16;
            fold = 1'b1;
        end else begin
            zf   = ang;
            fold = 1'b0;
        end
        ts = 23'(cur_h_reg) + $signed({3'd0, t17_reg[20:1]}) + ddo_pkg::PI_Q16;
        priority if (ts >= ddo_pkg::FOUR_PI_Q16) begin
            tw = ts - ddo_pkg::FOUR_PI_Q16;
        end else if (ts >= ddo_pkg::TWO_PI_Q16) begin
            tw = ts - ddo_pkg::TWO_PI_Q16;
        end else begin
            tw = ts;
        end
        hn = tw - ddo_pkg::PI_Q16;
    end

    // one CORDIC micro-rotation
    logic signed [33:0] xs, ys, cx_next, cy_next;
    logic signed [19:0] at, cz_next;
    logic signed [33:0] xo, yo;

    always_comb begin
        xs = cx_reg >>> step_reg;
        ys = cy_reg >>> step_reg;
        at = $signed({3'd0, ddo_pkg::atan_q16(step_reg)});
        if (cz_reg >= 20'sd0) begin
            cx_next = cx_reg - ys;
            cy_next = cy_reg + xs;
            cz_next = cz_reg - at;
        end else begin
            cx_next = cx_reg + ys;
            cy_next = cy_reg - xs;
            cz_next = cz_reg + at;
        end
        xo = cneg_reg ? -cx_reg : cx_reg;
        yo = cneg_reg ? -cy_reg : cy_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diam_reg       <= ddo_pkg::DIAMETER_RESET;
            base_reg       <= ddo_pkg::BASE_RESET;
            prev_right_reg <= 32'd0;
            prev_left_reg  <= 32'd0;
            cur_x_reg      <= 32'sd0;
            cur_y_reg      <= 32'sd0;
            cur_h_reg      <= 19'sd0;
            step_reg       <= 5'd0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == ddo_pkg::REG_WHEEL_DIAMETER) begin
                    diam_reg <= cfg_data;
                end else if (cfg_index == ddo_pkg::REG_WHEEL_BASE) begin
                    base_reg <= cfg_data;
                end
            end
            if (cmd.op == ddo_pkg::CMD_LOAD) begin
                prev_right_reg <= right_count;
                prev_left_reg  <= left_count;
            end
            if (cmd.op == ddo_pkg::CMD_ANGLE) begin
                step_reg <= 5'd0;
            end else if (cmd.op == ddo_pkg::CMD_CORDIC_STEP) begin
                step_reg <= step_reg + 5'd1;
            end
            if (cmd.op == ddo_pkg::CMD_COMMIT) begin
                cur_x_reg <= ddo_pkg::sat32(xsum_reg);
                cur_y_reg <= ddo_pkg::sat32(ysum_reg);
                cur_h_reg <= hnew_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            ddo_pkg::CMD_LOAD: begin
                dr_reg <= $signed(right_count - prev_right_reg);
                dl_reg <= $signed(left_count - prev_left_reg);
            end
            ddo_pkg::CMD_MUL_NUM:   prod_reg <= mul_p;
            ddo_pkg::CMD_DPD_START: prod_reg <= mul_p;
            ddo_pkg::CMD_MUL_TR: begin
                dpd_reg  <= dpd_val;
                prod_reg <= mul_p;
            end
            ddo_pkg::CMD_MUL_TL: begin
                tr_reg   <= prod_reg[57:0];
                prod_reg <= mul_p;
            end
            ddo_pkg::CMD_SUMS: begin
                mq_reg   <= mean_clamped[41:0];
                vneg_reg <= diff60[59];
                vmag_reg <= {diff_mag[57:0], 1'b0};
            end
            ddo_pkg::CMD_TURN: t17_reg <= t17_val;
            ddo_pkg::CMD_ANGLE: begin
                hnew_reg <= hn[18:0];
                cx_reg   <= ddo_pkg::CORDIC_K;
                cy_reg   <= 34'sd0;
                cz_reg   <= zf[19:0];
                cneg_reg <= fold;
            end
            ddo_pkg::CMD_CORDIC_STEP: begin
                cx_reg <= cx_next;
                cy_reg <= cy_next;
                cz_reg <= cz_next;
            end
            ddo_pkg::CMD_TRIG: begin
                cos_reg <= xo[33:8];
                sin_reg <= yo[33:8];
            end
            ddo_pkg::CMD_MXLO: prod_reg <= mul_p;
            ddo_pkg::CMD_MXHI: begin
                acc_lo_reg <= prod_reg;
                prod_reg   <= mul_p;
            end
            ddo_pkg::CMD_MYLO: begin
                full_reg <= (prod_reg <<< 21) + acc_lo_reg;
                prod_reg <= mul_p;
            end
            ddo_pkg::CMD_MYHI: begin
                xsum_reg   <= 42'(cur_x_reg) + full_reg[63:22];
                acc_lo_reg <= prod_reg;
                prod_reg   <= mul_p;
            end
            ddo_pkg::CMD_YFULL: full_reg <= (prod_reg <<< 21) + acc_lo_reg;
            ddo_pkg::CMD_YSUM:  ysum_reg <= 42'(cur_y_reg) + full_reg[63:22];
            ddo_pkg::CMD_COMMIT: begin
                out_x_reg <= ddo_pkg::sat32(xsum_reg);
                out_y_reg <= ddo_pkg::sat32(ysum_reg);
                out_h_reg <= hnew_reg;
            end
            default: begin
            end
        endcase
    end

    assign status.div_busy    = div_busy;
    assign status.cordic_last = (step_reg == ddo_pkg::CORDIC_LAST);
    assign pos_x   = out_x_reg;
    assign pos_y   = out_y_reg;
    assign heading = out_h_reg;

endmodule

`default_nettype wire

FILE: hdl/ddo_ctrl.sv
// Controller: sequences the datapath through one odometry update and owns both handshakes.
// Depends on ddo_pkg.
`default_nettype none

module ddo_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ddo_pkg::ctrl_cmd_t       cmd,
    input  wire ddo_pkg::dp_status_t status
);

    ddo_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;
    logic            slot_free;

    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ddo_pkg::ST_IDLE:       if (s_valid) state_next = ddo_pkg::ST_MUL_NUM;
            ddo_pkg::ST_MUL_NUM:    state_next = ddo_pkg::ST_DPD_START;
            ddo_pkg::ST_DPD_START:  state_next = ddo_pkg::ST_MUL_TR;
            ddo_pkg::ST_MUL_TR:     state_next = ddo_pkg::ST_MUL_TL;
            ddo_pkg::ST_MUL_TL:     state_next = ddo_pkg::ST_SUMS;
            ddo_pkg::ST_SUMS:       state_next = ddo_pkg::ST_TURN_START;
            ddo_pkg::ST_TURN_START: state_next = ddo_pkg::ST_TURN_WAIT;
            ddo_pkg::ST_TURN_WAIT:  if (!status.div_busy) state_next = ddo_pkg::ST_TURN;
            ddo_pkg::ST_TURN:       state_next = ddo_pkg::ST_ANGLE;
            ddo_pkg::ST_ANGLE:      state_next = ddo_pkg::ST_CORDIC;
            ddo_pkg::ST_CORDIC:     if (status.cordic_last) state_next = ddo_pkg::ST_TRIG;
            ddo_pkg::ST_TRIG:       state_next = ddo_pkg::ST_MXLO;
            ddo_pkg::ST_MXLO:       state_next = ddo_pkg::ST_MXHI;
            ddo_pkg::ST_MXHI:       state_next = ddo_pkg::ST_MYLO;
            ddo_pkg::ST_MYLO:       state_next = ddo_pkg::ST_MYHI;
            ddo_pkg::ST_MYHI:       state_next = ddo_pkg::ST_YFULL;
            ddo_pkg::ST_YFULL:      state_next = ddo_pkg::ST_YSUM;
            ddo_pkg::ST_YSUM:       state_next = ddo_pkg::ST_COMMIT;
            ddo_pkg::ST_COMMIT:     if (slot_free) state_next = ddo_pkg::ST_IDLE;
            default:                state_next = ddo_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.op  = ddo_pkg::CMD_NONE;
        s_ready = 1'b0;
        unique case (state_reg)
            ddo_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) cmd.op = ddo_pkg::CMD_LOAD;
            end
            ddo_pkg::ST_MUL_NUM:    cmd.op = ddo_pkg::CMD_MUL_NUM;
            ddo_pkg::ST_DPD_START:  cmd.op = ddo_pkg::CMD_DPD_START;
            ddo_pkg::ST_MUL_TR:     cmd.op = ddo_pkg::CMD_MUL_TR;
            ddo_pkg::ST_MUL_TL:     cmd.op = ddo_pkg::CMD_MUL_TL;
            ddo_pkg::ST_SUMS:       cmd.op = ddo_pkg::CMD_SUMS;
            ddo_pkg::ST_TURN_START: cmd.op = ddo_pkg::CMD_TURN_START;
            ddo_pkg::ST_TURN:       cmd.op = ddo_pkg::CMD_TURN;
            ddo_pkg::ST_ANGLE:      cmd.op = ddo_pkg::CMD_ANGLE;
            ddo_pkg::ST_CORDIC:     cmd.op = ddo_pkg::CMD_CORDIC_STEP;
            ddo_pkg::ST_TRIG:       cmd.op = ddo_pkg::CMD_TRIG;
            ddo_pkg::ST_MXLO:       cmd.op = ddo_pkg::CMD_MXLO;
            ddo_pkg::ST_MXHI:       cmd.op = ddo_pkg::CMD_MXHI;
            ddo_pkg::ST_MYLO:       cmd.op = ddo_pkg::CMD_MYLO;
            ddo_pkg::ST_MYHI:       cmd.op = ddo_pkg::CMD_MYHI;
            ddo_pkg::ST_YFULL:      cmd.op = ddo_pkg::CMD_YFULL;
            ddo_pkg::ST_YSUM:       cmd.op = ddo_pkg::CMD_YSUM;
            ddo_pkg::ST_COMMIT:     if (slot_free) cmd.op = ddo_pkg::CMD_COMMIT;
            default:                cmd.op = ddo_pkg::CMD_NONE;
        endcase
    end

    // hold the result until taken; a commit refills the slot
    always_comb begin
        if (cmd.op == ddo_pkg::CMD_COMMIT) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ddo_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

FILE: hdl/differential_drive_odometry_core.sv
// Top level of the differential drive odometry core: controller, datapath and checks.
// Depends on ddo_pkg, ddo_ctrl and ddo_datapath.
//
// Usage:
//   Input channel (s_valid/s_ready) carries the absolute right and left encoder counts
//   in degrees. Each transaction yields exactly one result transaction on the output
//   channel (m_valid/m_ready): saturating x and y in Q15.16 cm and the heading in
//   Q2.16 radians, wrapped into [-pi, pi].
//   Configuration port (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
//   index 0 sets the wheel diameter, index 1 the wheel base, both Q8.8 cm. Write it
//   only while no update is in flight.
//   After an input is accepted, m_valid rises once the controller has stepped through
//   its states, set mostly by the serial turn divider (59 steps) and the 17 CORDIC steps.
//   One update is worked on at a time; the next input is taken in the cycle after the
//   commit of the current one.
//   The output register holds a finished result while the receiver stalls; the next
//   transaction is accepted meanwhile and waits in its final step until the slot frees.
//   Reset clears the pose and previous counts to zero and loads the default wheel
//   geometry (8 cm diameter, 16 cm base).
`default_nettype none

module differential_drive_odometry_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic signed [31:0]              s_right_count,
    input  wire logic signed [31:0]              s_left_count,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic signed [31:0]                   m_pos_x,
    output logic signed [31:0]                   m_pos_y,
    output logic signed [18:0]                   m_heading,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ddo_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [15:0]                     cfg_data
);

    ddo_pkg::ctrl_cmd_t  cmd;
    ddo_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    ddo_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    ddo_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .right_count (s_right_count),
        .left_count  (s_left_count),
        .pos_x       (m_pos_x),
        .pos_y       (m_pos_y),
        .heading     (m_heading)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an update was in flight");

    a_commit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == ddo_pkg::CMD_COMMIT) |-> (!m_valid || m_ready))
        else $error("result committed over an untaken result");

    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_heading >= -19'sd205887 && m_heading <= 19'sd205887))
        else $error("heading outside the wrapped range");

    a_divider_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !status.div_busy)
        else $error("divider busy while waiting for input");

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for differential_drive_odometry_core: predicts each pose update
// in fixed point and compares it field by field with the result channel.
// Depends on ddo_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        logic [31:0] right;
        logic [31:0] left;
    } counts_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [18:0] hd;
    } pose_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_right_count = '0;
    logic signed [31:0] s_left_count = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_pos_x;
    logic signed [31:0] m_pos_y;
    logic signed [18:0] m_heading;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [ddo_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    differential_drive_odometry_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_right_count(s_right_count), .s_left_count(s_left_count),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pos_x(m_pos_x), .m_pos_y(m_pos_y), .m_heading(m_heading),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Predictor state
    logic [15:0] diameter_q8 = ddo_pkg::DIAMETER_RESET;
    logic [15:0] base_q8 = ddo_pkg::BASE_RESET;
    logic [31:0] last_right = '0;
    logic [31:0] last_left = '0;
    longint pose_x = 0;
    longint pose_y = 0;
    longint pose_hd = 0;

    counts_t pending_counts[$];
    pose_t expected_poses[$];
    int errors = 0;
    int poses_seen = 0;
    int reg_writes = 0;
    int cycles = 0;
    bit quiet = 1'b0;
    int send_gap = 0;
    int recv_stall = 0;
    logic [31:0] gen_right = '0;
    logic [31:0] gen_left = '0;

    function automatic longint div_floor(longint v, longint b);
        longint q;
        q = v / b;
        if ((v % b) != 0 && v < 0) q = q - 1;
        return q;
    endfunction

    function automatic longint wrap_pi(longint v);
        longint r;
        r = (v + 205887) % 411775;
        if (r < 0) r = r + 411775;
        return r - 205887;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic pose_t advance_pose(logic [31:0] r, logic [31:0] l);
        longint dr, dl, num, den, dpd, tr, tl, mean, bs, t17, ang, cx, sy, rz, xs, ys, mq;
        bit neg;
        pose_t p;
        dr = longint'(int'(r - last_right));
        dl = longint'(int'(l - last_left));
        num = longint'(diameter_q8) * 64'sd13493037705;
        den = 64'sd360 * 64'sd65536;
        dpd = (num + den / 2) / den;
        tr = dpd * dr;
        tl = dpd * dl;
        mean = (tr + tl) >>> 1;
        bs = (base_q8 != 0) ? longint'(base_q8) : 1;
        t17 = div_floor((tr - tl) * 2, bs) % 1647100;
        if (t17 < 0) t17 = t17 + 1647100;
        last_right = r;
        last_left = l;
        ang = wrap_pi(pose_hd + (t17 >>> 2));
        // fold by pi so the rotation stays within its convergence range
        neg = 1'b0;
        rz = ang;
        if (rz > 102944) begin
            rz = rz - 205887;
            neg = 1'b1;
        end else if (rz < -102944) begin
            rz = rz + 205887;
            neg = 1'b1;
        end
        cx = 652032874;
        sy = 0;
        for (int i = 0; i < 17; i++) begin
            xs = cx >>> i;
            ys = sy >>> i;
            if (rz >= 0) begin
                cx = cx - ys;
                sy = sy + xs;
                rz = rz - longint'(ddo_pkg::atan_q16(5'(i)));
            end else begin
                cx = cx + ys;
                sy = sy - xs;
                rz = rz + longint'(ddo_pkg::atan_q16(5'(i)));
            end
        end
        if (neg) begin
            cx = -cx;
            sy = -sy;
        end
        cx = cx >>> 8;
        sy = sy >>> 8;
        mq = mean >>> 8;
        if (mq > (64'sd1 << 40)) mq = 64'sd1 << 40;
        if (mq < -(64'sd1 << 40)) mq = -(64'sd1 << 40);
        pose_x = clip32(pose_x + ((mq * cx) >>> 22));
        pose_y = clip32(pose_y + ((mq * sy) >>> 22));
        pose_hd = wrap_pi(pose_hd + (t17 >>> 1));
        p.x = pose_x[31:0];
        p.y = pose_y[31:0];
        p.hd = pose_hd[18:0];
        return p;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("[%0t] MISMATCH %s: got %0d expected %0d", $time, what, got, want);
    endtask

    // Driver
    always @(posedge aclk) begin
        counts_t c;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && !s_ready)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_counts.size() > 0) begin
                c = pending_counts.pop_front();
                s_valid <= 1'b1;
                s_right_count <= c.right;
                s_left_count <= c.left;
                if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 14);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        if (recv_stall > 0) begin
            recv_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0) recv_stall = $urandom_range(1, 14);
        end
    end

    // Monitor
    always @(posedge aclk) begin
        pose_t want;
        cycles++;
        if (aresetn) begin
            if (s_valid && s_ready) expected_poses.push_back(advance_pose(s_right_count, s_left_count));
            if (m_valid && m_ready) begin
                poses_seen++;
                if (expected_poses.size() == 0) begin
                    report_mismatch("result with none expected, pos_x", m_pos_x, 0);
                end else begin
                    want = expected_poses.pop_front();
                    if (m_pos_x !== want.x) report_mismatch("pos_x", m_pos_x, want.x);
                    if (m_pos_y !== want.y) report_mismatch("pos_y", m_pos_y, want.y);
                    if (m_heading !== want.hd) report_mismatch("heading", m_heading, want.hd);
                end
            end
        end
        if (cycles > 2000000) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_counts.size() != 0 || s_valid || expected_poses.size() != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [ddo_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == ddo_pkg::REG_WHEEL_DIAMETER) diameter_q8 = val;
        else if (idx == ddo_pkg::REG_WHEEL_BASE) base_q8 = val;
        reg_writes++;
    endtask

    task automatic queue_counts(input logic [31:0] r, input logic [31:0] l);
        counts_t c;
        c.right = r;
        c.left = l;
        gen_right = r;
        gen_left = l;
        pending_counts.push_back(c);
    endtask

    // Mostly plausible wheel motion, with some far jumps and raw noise
    task automatic queue_random(input int n);
        int sel;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 65)
                queue_counts(gen_right + $urandom_range(0, 4000) - 2000,
                             gen_left + $urandom_range(0, 4000) - 2000);
            else if (sel < 85)
                queue_counts(gen_right + $urandom_range(0, 2097152) - 1048576,
                             gen_left + $urandom_range(0, 2097152) - 1048576);
            else
                queue_counts($urandom, $urandom);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset geometry: straight runs, spins, roll-over and extreme counts
        queue_counts(0, 0);
        queue_counts(360, 360);
        queue_counts(1080, 360);
        queue_counts(360, 1080);
        queue_counts(-360, 2000);
        queue_counts(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_counts(32'h8000_0000, 32'h8000_0000);
        queue_counts(32'h7FFF_FFFF, 32'h8000_0000);
        queue_counts(32'h8000_0000, 32'h7FFF_FFFF);
        queue_counts(32'hFFFF_FFFF, 32'h0000_0001);
        queue_counts(0, 0);
        for (int k = 0; k < 8; k++) queue_counts(gen_right + 400000, gen_left + 400000);
        wait_drained();

        // Largest wheels on the narrowest base: clamped travel, saturation, wild turns
        write_reg(ddo_pkg::REG_WHEEL_DIAMETER, 16'hFFFF);
        write_reg(ddo_pkg::REG_WHEEL_BASE, 16'd1);
        queue_counts(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_counts(32'hFFFF_FFFF, 32'h8000_0000);
        queue_counts(32'h8000_0000, 32'h7FFF_FFFF);
        queue_random(170);
        wait_drained();

        write_reg(ddo_pkg::REG_WHEEL_DIAMETER, 16'd1);
        write_reg(ddo_pkg::REG_WHEEL_BASE, 16'hFFFF);
        queue_random(170);
        wait_drained();

        // A zero base behaves as the smallest one
        write_reg(ddo_pkg::REG_WHEEL_DIAMETER, 16'd3000);
        write_reg(ddo_pkg::REG_WHEEL_BASE, 16'd0);
        queue_random(170);
        wait_drained();

        write_reg(ddo_pkg::REG_WHEEL_DIAMETER, ddo_pkg::DIAMETER_RESET);
        write_reg(ddo_pkg::REG_WHEEL_BASE, ddo_pkg::BASE_RESET);
        queue_random(170);
        wait_drained();

        write_reg(ddo_pkg::REG_WHEEL_DIAMETER, 16'($urandom_range(1, 65535)));
        write_reg(ddo_pkg::REG_WHEEL_BASE, 16'($urandom_range(1, 65535)));
        queue_random(170);
        wait_drained();

        // Back-to-back traffic, no idling on either side
        quiet = 1'b1;
        write_reg(ddo_pkg::REG_WHEEL_DIAMETER, 16'($urandom_range(256, 8192)));
        write_reg(ddo_pkg::REG_WHEEL_BASE, 16'($urandom_range(1024, 16384)));
        queue_random(150);
        wait_drained();

        $display("Covered %0d pose updates over %0d geometry register writes,", poses_seen,
                 reg_writes);
        $display("including count roll-over, travel clamp, saturation and zero base.");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/ddo_pkg.sv
hdl/ddo_divider.sv
hdl/ddo_datapath.sv
hdl/ddo_ctrl.sv
hdl/differential_drive_odometry_core.sv
verif/tb_top.sv
